// ===== sv/vrra_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the variable record ring allocator.
// Field widths, operation and status codes, controller states, result struct.
// No dependencies.
package vrra_pkg;

  // Widths of the transaction fields
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned BYTES_W  = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned SIZE_W   = 13;

  // Requested size after rounding up to 8 bytes needs one bit more
  localparam int unsigned RSZ_W = BYTES_W + 1;
  localparam logic [RSZ_W-1:0] ALIGN_LOW = RSZ_W'(7);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLAIM   = 2'd0,
    FUNC_PUBLISH = 2'd1,
    FUNC_FRONT   = 2'd2,
    FUNC_POP     = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_SIZE_REJECT  = 3'd1,
    ST_NO_SPACE     = 3'd2,
    ST_PAD_NO_SPACE = 3'd3,
    ST_EMPTY        = 3'd4,
    ST_CORRUPT      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLAIM,
    S_CLAIM_REC,
    S_HDR_FIRST,
    S_HDR_SECOND,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] rec_offset;
    logic [SIZE_W-1:0]   rec_size;
    logic                queue_empty;
  } rsp_t;

endpackage

// ===== sv/vrra_req_if.sv =====
`timescale 1ns / 1ps
// Request channel of the ring allocator: operation code and requested size.
// Depends on vrra_pkg.
interface vrra_req_if;
  logic                         valid;
  logic                         ready;
  logic [vrra_pkg::FUNC_W-1:0]  func;
  logic [vrra_pkg::BYTES_W-1:0] record_bytes;

  modport source (output valid, output func, output record_bytes, input ready);
  modport sink   (input valid, input func, input record_bytes, output ready);
endinterface

// ===== sv/vrra_rsp_if.sv =====
`timescale 1ns / 1ps
// Response channel of the ring allocator: status, record offset and size, empty flag.
// Depends on vrra_pkg.
interface vrra_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [vrra_pkg::STATUS_W-1:0] status;
  logic [vrra_pkg::OFFSET_W-1:0] rec_offset;
  logic [vrra_pkg::SIZE_W-1:0]   rec_size;
  logic                          queue_empty;

  modport source (output valid, output status, output rec_offset, output rec_size,
                  output queue_empty, input ready);
  modport sink   (input valid, input status, input rec_offset, input rec_size,
                  input queue_empty, output ready);
endinterface

// ===== sv/vrra_ctrl.sv =====
`timescale 1ns / 1ps
// Allocator controller: pointers, header memory and the sequencer that claims,
// publishes, locates and pops records. Depends on vrra_pkg and vrra_req_if.
module vrra_ctrl #(
  parameter int unsigned RING_BYTES       = 4096,
  parameter int unsigned MIN_RECORD_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst,
  vrra_req_if.sink           req,
  output logic               res_valid,
  input  logic               res_ready,
  output vrra_pkg::rsp_t     res
);

  localparam int unsigned OFF_W  = $clog2(RING_BYTES);
  localparam int unsigned PTR_W  = OFF_W + 1;
  localparam int unsigned SLOT_W = OFF_W - 3;
  localparam int unsigned SLOTS  = RING_BYTES / 8;
  localparam int unsigned HSZ_W  = SLOT_W + 1;
  localparam int unsigned HDR_W  = HSZ_W + 1;
  localparam int unsigned SUM_W  = PTR_W + 1;
  localparam int unsigned RW     = (vrra_pkg::RSZ_W > PTR_W) ? vrra_pkg::RSZ_W : PTR_W;

  // Control and pointer registers
  vrra_pkg::state_t  state, state_next;
  logic [PTR_W-1:0]  wp, wp_next;
  logic [PTR_W-1:0]  pp, pp_next;
  logic [PTR_W-1:0]  rp, rp_next;

  // Latched request and pending result
  vrra_pkg::func_t              op_func;
  logic [vrra_pkg::BYTES_W-1:0] op_bytes;
  vrra_pkg::status_t            res_status, res_status_next;
  logic [OFF_W-1:0]             res_off, res_off_next;
  logic [PTR_W-1:0]             res_size, res_size_next;

  // Header memory port
  logic [HDR_W-1:0]  hdr_mem [SLOTS];
  logic              hdr_we, hdr_re;
  logic [SLOT_W-1:0] hdr_waddr, hdr_raddr;
  logic [HDR_W-1:0]  hdr_wdata, hdr_rdata;

  // Claim datapath
  logic [vrra_pkg::RSZ_W-1:0] size_c;
  logic [RW-1:0]              size_w;
  logic                       size_rej;
  logic [PTR_W-1:0]           size_p, to_end, pad, need, used, rec_ptr;
  logic [OFF_W-1:0]           wo, rec_off;
  logic                       pad_nz, pad_fail, need_fail;

  // Locate datapath
  logic             hdr_pad;
  logic [PTR_W-1:0] hb, rp_skip;
  logic [OFF_W-1:0] ro;
  logic             hdr_bad;
  logic             req_ready;

  assign req.ready = req_ready;

  // Round the size up and work out padding and free space
  always_comb begin
    size_c    = (vrra_pkg::RSZ_W'(op_bytes) + vrra_pkg::ALIGN_LOW) & ~vrra_pkg::ALIGN_LOW;
    size_w    = RW'(size_c);
    size_rej  = (size_w < RW'(MIN_RECORD_BYTES)) || (size_w > RW'(RING_BYTES));
    size_p    = size_w[PTR_W-1:0];
    wo        = wp[OFF_W-1:0];
    to_end    = PTR_W'(RING_BYTES) - PTR_W'(wo);
    pad_nz    = size_w > RW'(to_end);
    pad       = pad_nz ? to_end : '0;
    need      = pad + size_p;
    used      = wp - rp;
    pad_fail  = (SUM_W'(pad) + SUM_W'(used)) > SUM_W'(RING_BYTES);
    need_fail = (SUM_W'(need) + SUM_W'(used)) > SUM_W'(RING_BYTES);
    rec_ptr   = wp + pad;
    rec_off   = rec_ptr[OFF_W-1:0];
  end

  // Decode the header read back and check it against the ring
  always_comb begin
    hdr_pad = hdr_rdata[HDR_W-1];
    hb      = {hdr_rdata[HSZ_W-1:0], 3'b000};
    rp_skip = rp + hb;
    ro      = rp[OFF_W-1:0];
    hdr_bad = (hb < PTR_W'(MIN_RECORD_BYTES))
           || (hb > (PTR_W'(RING_BYTES) - PTR_W'(ro)))
           || (hb > used);
  end

  // Sequencer: next state, pointer updates, memory accesses
  always_comb begin
    state_next      = state;
    wp_next         = wp;
    pp_next         = pp;
    rp_next         = rp;
    res_status_next = res_status;
    res_off_next    = res_off;
    res_size_next   = res_size;
    hdr_we          = 1'b0;
    hdr_waddr       = wo[OFF_W-1:3];
    hdr_wdata       = '0;
    hdr_re          = 1'b0;
    hdr_raddr       = ro[OFF_W-1:3];
    req_ready       = 1'b0;
    res_valid       = 1'b0;

    unique case (state)
      vrra_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req.valid) begin
          unique case (vrra_pkg::func_t'(req.func)) inside
            vrra_pkg::FUNC_CLAIM: begin
              state_next = vrra_pkg::S_CLAIM;
            end
            vrra_pkg::FUNC_PUBLISH: begin
              wp_next         = pp;
              res_status_next = vrra_pkg::ST_OK;
              res_off_next    = '0;
              res_size_next   = '0;
              state_next      = vrra_pkg::S_RESP;
            end
            vrra_pkg::FUNC_FRONT, vrra_pkg::FUNC_POP: begin
              if (rp == wp) begin
                res_status_next = vrra_pkg::ST_EMPTY;
                res_off_next    = '0;
                res_size_next   = '0;
                state_next      = vrra_pkg::S_RESP;
              end else begin
                hdr_re     = 1'b1;
                state_next = vrra_pkg::S_HDR_FIRST;
              end
            end
          endcase
        end
      end

      vrra_pkg::S_CLAIM: begin
        res_off_next  = '0;
        res_size_next = '0;
        state_next    = vrra_pkg::S_RESP;
        if (size_rej) begin
          res_status_next = vrra_pkg::ST_SIZE_REJECT;
        end else if (pad_nz) begin
          if (pad_fail) begin
            res_status_next = vrra_pkg::ST_NO_SPACE;
          end else begin
            // Place the padding header at the end of the ring
            hdr_we    = 1'b1;
            hdr_wdata = {1'b1, pad[PTR_W-1:3]};
            if (need_fail) begin
              wp_next         = wp + pad;
              res_status_next = vrra_pkg::ST_PAD_NO_SPACE;
            end else begin
              state_next = vrra_pkg::S_CLAIM_REC;
            end
          end
        end else if (need_fail) begin
          res_status_next = vrra_pkg::ST_NO_SPACE;
        end else begin
          hdr_we          = 1'b1;
          hdr_waddr       = rec_off[OFF_W-1:3];
          hdr_wdata       = {1'b0, size_p[PTR_W-1:3]};
          pp_next         = wp + need;
          res_status_next = vrra_pkg::ST_OK;
          res_off_next    = rec_off;
          res_size_next   = size_p;
        end
      end

      // Second write of a wrapping claim: the record header at the ring start
      vrra_pkg::S_CLAIM_REC: begin
        hdr_we          = 1'b1;
        hdr_waddr       = rec_off[OFF_W-1:3];
        hdr_wdata       = {1'b0, size_p[PTR_W-1:3]};
        pp_next         = wp + need;
        res_status_next = vrra_pkg::ST_OK;
        res_off_next    = rec_off;
        res_size_next   = size_p;
        state_next      = vrra_pkg::S_RESP;
      end

      vrra_pkg::S_HDR_FIRST: begin
        state_next = vrra_pkg::S_RESP;
        if (hdr_pad) begin
          // Skip the padding record and fetch the one after it
          rp_next = rp_skip;
          if (rp_skip == wp) begin
            res_status_next = vrra_pkg::ST_EMPTY;
            res_off_next    = '0;
            res_size_next   = '0;
          end else begin
            hdr_re     = 1'b1;
            hdr_raddr  = rp_skip[OFF_W-1:3];
            state_next = vrra_pkg::S_HDR_SECOND;
          end
        end else if (hdr_bad) begin
          res_status_next = vrra_pkg::ST_CORRUPT;
          res_off_next    = ro;
          res_size_next   = '0;
        end else begin
          res_status_next = vrra_pkg::ST_OK;
          res_off_next    = ro;
          res_size_next   = hb;
          if (op_func == vrra_pkg::FUNC_POP) begin
            rp_next = rp_skip;
          end
        end
      end

      vrra_pkg::S_HDR_SECOND: begin
        state_next = vrra_pkg::S_RESP;
        if (hdr_pad || hdr_bad) begin
          res_status_next = vrra_pkg::ST_CORRUPT;
          res_off_next    = ro;
          res_size_next   = '0;
        end else begin
          res_status_next = vrra_pkg::ST_OK;
          res_off_next    = ro;
          res_size_next   = hb;
          if (op_func == vrra_pkg::FUNC_POP) begin
            rp_next = rp_skip;
          end
        end
      end

      vrra_pkg::S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = vrra_pkg::S_IDLE;
        end
      end
    endcase
  end

  // Hold state and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vrra_pkg::S_IDLE;
      wp    <= '0;
      pp    <= '0;
      rp    <= '0;
    end else begin
      state <= state_next;
      wp    <= wp_next;
      pp    <= pp_next;
      rp    <= rp_next;
    end
  end

  // Latch the transaction and the pending result
  always_ff @(posedge clk) begin
    if (req.valid && req_ready) begin
      op_func  <= vrra_pkg::func_t'(req.func);
      op_bytes <= req.record_bytes;
    end
    res_status <= res_status_next;
    res_off    <= res_off_next;
    res_size   <= res_size_next;
  end

  // Header memory, one write and one registered read per cycle; the sequencer
  // never reads and writes in the same cycle
  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_mem[hdr_waddr] <= hdr_wdata;
    end
    if (hdr_re) begin
      hdr_rdata <= hdr_mem[hdr_raddr];
    end
  end

  // Present the result with the empty flag after the update
  always_comb begin
    res.status      = res_status;
    res.rec_offset  = res_off[vrra_pkg::OFFSET_W-1:0];
    res.rec_size    = res_size[vrra_pkg::SIZE_W-1:0];
    res.queue_empty = (rp == wp);
  end

endmodule

// ===== sv/vrra_out_reg.sv =====
`timescale 1ns / 1ps
// Output register of the ring allocator: holds one response until it is taken.
// Depends on vrra_pkg and vrra_rsp_if.
module vrra_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  vrra_pkg::rsp_t in_data,
  vrra_rsp_if.source     rsp
);

  logic           full;
  vrra_pkg::rsp_t data;

  // Accept a new response when empty or when the held one leaves
  assign in_ready = !full || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (rsp.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_data;
    end
  end

  assign rsp.valid       = full;
  assign rsp.status      = data.status;
  assign rsp.rec_offset  = data.rec_offset;
  assign rsp.rec_size    = data.rec_size;
  assign rsp.queue_empty = data.queue_empty;

endmodule

// ===== sv/variable_record_ring_allocator.sv =====
`timescale 1ns / 1ps
// Space manager for a ring of RING_BYTES bytes holding variable-length
// records (headers only, no payloads). Each request transaction yields exactly
// one response transaction. Requests are handled one at a time: a publish goes
// to the response state; a claim passes the claim state, and a second write
// state when it wraps and must write a padding header and a record header
// through the single write port of the header memory; a front or pop on an empty
// ring goes to the response state, else it reads a header, and also the one
// behind it when that is a padding record, since each header read is registered.
// A response waits in an output register, so the next request is taken as soon
// as the sequencer is free; while that register still holds a response that has
// not been taken, the sequencer holds its result and takes no request.
// The header memory needs no clearing after reset. RING_BYTES must be a power of
// two. Depends on vrra_pkg, vrra_req_if, vrra_rsp_if, vrra_ctrl, vrra_out_reg.
module variable_record_ring_allocator #(
  parameter int unsigned RING_BYTES       = 4096,
  parameter int unsigned MIN_RECORD_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  vrra_req_if.sink   req,
  vrra_rsp_if.source rsp
);

  logic           res_valid;
  logic           res_ready;
  vrra_pkg::rsp_t res;

  // Sequencer with pointers and header memory
  vrra_ctrl #(
    .RING_BYTES       (RING_BYTES),
    .MIN_RECORD_BYTES (MIN_RECORD_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Response register
  vrra_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_ready (res_ready),
    .in_data  (res),
    .rsp      (rsp)
  );

endmodule

// ===== test/vrra_ring_checker.sv =====
`timescale 1ns / 1ps
// Transaction checker for the variable record ring allocator: watches both channels,
// keeps its own copy of the ring pointers and slot headers and compares every response.
// Depends on vrra_pkg, vrra_req_if, vrra_rsp_if.
module vrra_ring_checker #(
  parameter int unsigned RING_BYTES       = 4096,
  parameter int unsigned MIN_RECORD_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  vrra_req_if         req,
  vrra_rsp_if         rsp,
  output int unsigned fail_count,
  output logic        head_safe,
  output int unsigned outstanding
);
  import vrra_pkg::*;

  localparam int unsigned SLOTS    = RING_BYTES / 8;
  localparam int unsigned PTR_MASK = 2 * RING_BYTES - 1;
  localparam int unsigned OFF_MASK = RING_BYTES - 1;

  // Ring pointers count modulo twice the capacity
  int unsigned wr_ptr;
  int unsigned pend_ptr;
  int unsigned rd_ptr;

  // One header per 8-byte slot, plus a note of which slots have ever been written
  bit          slot_pad     [SLOTS];
  int unsigned slot_len     [SLOTS];
  bit          slot_written [SLOTS];

  rsp_t expected_rsp_q[$];

  function automatic int unsigned slot_of(input int unsigned off);
    return (off >> 3) & (SLOTS - 1);
  endfunction

  function automatic void store_header(input int unsigned off, input bit pad,
                                       input int unsigned len);
    slot_pad[slot_of(off)]     = pad;
    slot_len[slot_of(off)]     = len;
    slot_written[slot_of(off)] = 1'b1;
  endfunction

  // Oldest record: skip at most one padding record, which moves the read pointer
  function automatic status_t find_oldest(output int unsigned off, output int unsigned len);
    int unsigned o;
    int unsigned s;
    int unsigned used;
    off = 0;
    len = 0;
    for (int pass = 0; pass < 2; pass++) begin
      if (rd_ptr == wr_ptr) return ST_EMPTY;
      o   = rd_ptr & OFF_MASK;
      s   = slot_of(o);
      off = o;
      if (slot_pad[s]) begin
        // a second padding record in a row is treated as damage
        if (pass == 1) return ST_CORRUPT;
        rd_ptr = (rd_ptr + slot_len[s]) & PTR_MASK;
        continue;
      end
      used = (wr_ptr - rd_ptr) & PTR_MASK;
      if (slot_len[s] < MIN_RECORD_BYTES || slot_len[s] > RING_BYTES - o ||
          slot_len[s] > used) return ST_CORRUPT;
      len = slot_len[s];
      return ST_OK;
    end
    return ST_CORRUPT;
  endfunction

  // Reserve space, placing a padding header at the end of the ring when needed
  function automatic status_t claim_space(input logic [15:0] nbytes,
                                          output int unsigned off, output int unsigned len);
    int unsigned sz;
    int unsigned o;
    int unsigned to_end;
    int unsigned pad;
    int unsigned need;
    int unsigned used;
    longint      avail;
    off = 0;
    len = 0;
    sz  = (int'(nbytes) + 7) & ~32'd7;
    if (sz < MIN_RECORD_BYTES || sz > RING_BYTES) return ST_SIZE_REJECT;
    o      = wr_ptr & OFF_MASK;
    to_end = RING_BYTES - o;
    pad    = (sz > to_end) ? to_end : 0;
    need   = pad + sz;
    used   = (wr_ptr - rd_ptr) & PTR_MASK;
    // overfull pointers give a negative free space
    avail  = longint'(RING_BYTES) - longint'(used);
    if (pad != 0) begin
      if (longint'(pad) > avail) return ST_NO_SPACE;
      store_header(o, 1'b1, pad);
      if (longint'(need) > avail) begin
        wr_ptr = (wr_ptr + pad) & PTR_MASK;
        return ST_PAD_NO_SPACE;
      end
    end else if (longint'(need) > avail) begin
      return ST_NO_SPACE;
    end
    o = (wr_ptr + pad) & OFF_MASK;
    store_header(o, 1'b0, sz);
    pend_ptr = (wr_ptr + need) & PTR_MASK;
    off      = o;
    len      = sz;
    return ST_OK;
  endfunction

  function automatic rsp_t predict_response(input func_t f, input logic [15:0] nbytes);
    rsp_t        r;
    status_t     st;
    int unsigned off;
    int unsigned len;
    off = 0;
    len = 0;
    st  = ST_OK;
    case (f)
      FUNC_CLAIM:   st = claim_space(nbytes, off, len);
      FUNC_PUBLISH: wr_ptr = pend_ptr & PTR_MASK;
      FUNC_FRONT:   st = find_oldest(off, len);
      FUNC_POP: begin
        st = find_oldest(off, len);
        if (st == ST_OK) rd_ptr = (rd_ptr + len) & PTR_MASK;
      end
      default: st = ST_OK;
    endcase
    if (st != ST_OK && st != ST_CORRUPT) off = 0;
    if (st != ST_OK) len = 0;
    r.status      = st;
    r.rec_offset  = OFFSET_W'(off);
    r.rec_size    = SIZE_W'(len);
    r.queue_empty = (rd_ptr == wr_ptr);
    return r;
  endfunction

  // True when a front or pop now would only read slots that hold a written header
  function automatic bit header_reads_defined();
    int unsigned s;
    int unsigned next_rd;
    if (rd_ptr == wr_ptr) return 1'b1;
    s = slot_of(rd_ptr & OFF_MASK);
    if (!slot_written[s]) return 1'b0;
    if (!slot_pad[s]) return 1'b1;
    next_rd = (rd_ptr + slot_len[s]) & PTR_MASK;
    if (next_rd == wr_ptr) return 1'b1;
    return slot_written[slot_of(next_rd & OFF_MASK)];
  endfunction

  // Check each response transaction, then predict the request transaction of this edge
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (rst) begin
      wr_ptr     = 0;
      pend_ptr   = 0;
      rd_ptr     = 0;
      fail_count = 0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_pad[i]     = 1'b0;
        slot_len[i]     = 0;
        slot_written[i] = 1'b0;
      end
      expected_rsp_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = {rsp.status, rsp.rec_offset, rsp.rec_size, rsp.queue_empty};
        if (expected_rsp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: response with no request pending: status %0d offset %0d size %0d",
                     $realtime, got.status, got.rec_offset, got.rec_size);
        end else begin
          want = expected_rsp_q.pop_front();
          if (got.status !== want.status || got.rec_offset !== want.rec_offset ||
              got.rec_size !== want.rec_size || got.queue_empty !== want.queue_empty) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch: status %0d expected %0d, empty %0b expected %0b",
                       $realtime, got.status, want.status, got.queue_empty,
                       want.queue_empty);
              $display("  offset %0d expected %0d, size %0d expected %0d",
                       got.rec_offset, want.rec_offset, got.rec_size, want.rec_size);
            end
          end
        end
      end
      if (req.valid && req.ready) begin
        want = predict_response(func_t'(req.func), req.record_bytes);
        expected_rsp_q.insert(expected_rsp_q.size(), want);
      end
    end
    head_safe   = header_reads_defined();
    outstanding = expected_rsp_q.size();
  end

endmodule

// ===== test/tb_variable_record_ring_allocator.sv =====
`timescale 1ns / 1ps
// Testbench top for the variable record ring allocator: clock, reset, request and
// response drivers over several idling mixes, and the final verdict.
// Depends on vrra_pkg, vrra_req_if, vrra_rsp_if, vrra_ring_checker and the block.
module tb_variable_record_ring_allocator;
  import vrra_pkg::*;

  localparam int unsigned RING_BYTES       = 4096;
  localparam int unsigned MIN_RECORD_BYTES = 64;
  localparam int          ITEMS_PER_PHASE  = 375;
  localparam int          PRESSURE_PHASE   = 4;
  localparam int          HOLD_CYCLES      = 300;
  localparam int unsigned CYCLE_LIMIT      = 400000;

  logic        clk;
  logic        rst;
  int unsigned fail_count;
  logic        head_safe;
  int unsigned outstanding;

  int          phase_idx;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_left;
  bit          hold_done;
  int unsigned cycle_count;
  int unsigned op_count [4];

  vrra_req_if req_ch ();
  vrra_rsp_if rsp_ch ();

  variable_record_ring_allocator #(
    .RING_BYTES      (RING_BYTES),
    .MIN_RECORD_BYTES(MIN_RECORD_BYTES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  vrra_ring_checker #(
    .RING_BYTES      (RING_BYTES),
    .MIN_RECORD_BYTES(MIN_RECORD_BYTES)
  ) i_ring_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .head_safe  (head_safe),
    .outstanding(outstanding)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("variable_record_ring_allocator verification failed");
      $finish;
    end
  end

  // Response side: random stalls, and one long hold-off in the pressure phase
  initial begin
    rsp_ch.ready = 1'b0;
    hold_left    = 0;
    hold_done    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && phase_idx == PRESSURE_PHASE && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        rsp_ch.ready = 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Sizes: mostly valid and small, some near capacity, some rejected, some wild
  function automatic logic [15:0] pick_bytes();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(57, 700));
    if (r < 80) return 16'($urandom_range(701, 4096));
    if (r < 85) return 16'($urandom_range(4089, 4096));
    if (r < 92) return 16'($urandom_range(0, 63));
    if (r < 96) return 16'($urandom_range(4097, 65535));
    return 16'($urandom);
  endfunction

  // Offer one request transaction and hold it until accepted; entered and left at a
  // falling edge. A front or pop that would read a never-written slot becomes a claim.
  task automatic push_item(input func_t op, input logic [15:0] nbytes);
    func_t       f;
    logic [15:0] b;
    f = op;
    b = nbytes;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    if ((f == FUNC_FRONT || f == FUNC_POP) && !head_safe) begin
      f = FUNC_CLAIM;
      b = pick_bytes();
    end
    req_ch.valid        = 1'b1;
    req_ch.func         = f;
    req_ch.record_bytes = b;
    op_count[int'(f)]++;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int sent;
    int r;
    bit fill;
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.func         = FUNC_CLAIM;
    req_ch.record_bytes = '0;
    phase_idx           = 0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    cycle_count         = 0;
    for (int i = 0; i < 4; i++) op_count[i] = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: empty ring, publish without claim, size limits and rounding
    push_item(FUNC_FRONT, 16'hFFFF);
    push_item(FUNC_POP, 16'h0000);
    push_item(FUNC_PUBLISH, 16'h0000);
    push_item(FUNC_CLAIM, 16'd0);
    push_item(FUNC_CLAIM, 16'd56);
    push_item(FUNC_CLAIM, 16'd57);
    push_item(FUNC_CLAIM, 16'hFFFF);
    push_item(FUNC_CLAIM, 16'd4097);
    push_item(FUNC_PUBLISH, 16'hFFFF);
    push_item(FUNC_FRONT, 16'h0000);
    push_item(FUNC_POP, 16'h0000);
    // Wrap with padding but no room, front skipping the padding, full ring
    push_item(FUNC_CLAIM, 16'd4096);
    push_item(FUNC_FRONT, 16'h0000);
    push_item(FUNC_CLAIM, 16'd4096);
    push_item(FUNC_PUBLISH, 16'h0000);
    push_item(FUNC_CLAIM, 16'd64);
    push_item(FUNC_POP, 16'h0000);
    // Padding published then no space, drain, then a stale publish over it
    push_item(FUNC_CLAIM, 16'd3000);
    push_item(FUNC_PUBLISH, 16'h0000);
    push_item(FUNC_CLAIM, 16'd1000);
    push_item(FUNC_PUBLISH, 16'h0000);
    push_item(FUNC_CLAIM, 16'd512);
    push_item(FUNC_POP, 16'h0000);
    push_item(FUNC_POP, 16'h0000);
    push_item(FUNC_POP, 16'h0000);
    push_item(FUNC_PUBLISH, 16'h0000);
    push_item(FUNC_FRONT, 16'h0000);

    // Random phases: alternate fill-heavy and drain-heavy stretches
    for (int p = 0; p < 5; p++) begin
      case (p)
        1:       begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 84; end
        3:       begin send_idle_pct = 36; recv_stall_pct = 36; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      phase_idx = p;
      sent      = 0;
      while (sent < ITEMS_PER_PHASE) begin
        fill = (((sent + 30 * p) / 60) % 2) == 0;
        r    = $urandom_range(99);
        if (r < (fill ? 55 : 15)) begin
          push_item(FUNC_CLAIM, pick_bytes());
          push_item(FUNC_PUBLISH, 16'($urandom));
          sent += 2;
        end else begin
          if (r < (fill ? 65 : 30))      push_item(FUNC_FRONT, 16'($urandom));
          else if (r < (fill ? 80 : 85)) push_item(FUNC_POP, 16'($urandom));
          else if (r < (fill ? 88 : 90)) push_item(FUNC_CLAIM, pick_bytes());
          else if (r < 95)               push_item(FUNC_PUBLISH, 16'($urandom));
          else                           push_item(FUNC_CLAIM, 16'($urandom));
          sent++;
        end
      end
    end
    req_ch.valid = 1'b0;

    // Drain outstanding responses, then let the block settle
    for (int k = 0; k < 20000 && outstanding != 0; k++) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d requests: %0d claims, %0d publishes, %0d fronts, %0d pops.",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[int'(FUNC_CLAIM)], op_count[int'(FUNC_PUBLISH)],
             op_count[int'(FUNC_FRONT)], op_count[int'(FUNC_POP)]);
    $display("Idling: none, sender 84%%, receiver 84%%, both 36%%, %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0 && outstanding == 0) begin
      $display("variable_record_ring_allocator verification clean");
    end else begin
      $display("variable_record_ring_allocator verification failed");
    end
    $finish;
  end

endmodule
